// ----- rtl/core/i2cm_pkg.sv -----
`default_nettype none

package i2cm_pkg;

  localparam int DelayBitsDef    = 16;
  localparam int HalfBitDelayRst = 100;
  localparam int AckPollLimitRst = 255;
  localparam int PollBits        = 8;
  localparam int CfgDataW        = 16;
  localparam int CfgIdxW         = 1;
  localparam int ByteBits        = 8;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgHalfBitDelay = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgAckPollLimit = 1'd1;

  typedef enum logic [2:0] {
    ReqTick    = 3'd0,
    ReqStart   = 3'd1,
    ReqStop    = 3'd2,
    ReqWrite   = 3'd3,
    ReqRead    = 3'd4,
    ReqReadAck = 3'd5
  } req_e;

  typedef struct packed {
    logic                scl;
    logic                sda;
    logic                oe;
    logic                busy;
    logic                done;
    logic                ack;
    logic [ByteBits-1:0] rd_data;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/i2cm_cfg_regs.sv -----
`default_nettype none

module i2cm_cfg_regs #(
  parameter int DelayBits = i2cm_pkg::DelayBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [i2cm_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic      [DelayBits-1:0]         half_bit_delay_o,
  output logic      [i2cm_pkg::PollBits-1:0] ack_poll_limit_o
);

  logic [DelayBits-1:0]          hbd_q, hbd_d;
  logic [i2cm_pkg::PollBits-1:0] apl_q, apl_d;

  always_comb begin
    hbd_d = hbd_q;
    apl_d = apl_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        i2cm_pkg::CfgHalfBitDelay: begin
          hbd_d = DelayBits'(cfg_wdata_i);
        end
        i2cm_pkg::CfgAckPollLimit: begin
          apl_d = cfg_wdata_i[i2cm_pkg::PollBits-1:0];
        end
        default: begin
          hbd_d = hbd_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hbd_q <= DelayBits'(i2cm_pkg::HalfBitDelayRst);
      apl_q <= i2cm_pkg::PollBits'(i2cm_pkg::AckPollLimitRst);
    end else begin
      hbd_q <= hbd_d;
      apl_q <= apl_d;
    end
  end

  assign half_bit_delay_o = hbd_q;
  assign ack_poll_limit_o = apl_q;

endmodule

`default_nettype wire

// ----- rtl/core/i2cm_line_fsm.sv -----
`default_nettype none

module i2cm_line_fsm #(
  parameter int DelayBits = i2cm_pkg::DelayBitsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire logic [2:0]                     req_type_i,
  input  wire logic [i2cm_pkg::ByteBits-1:0]  write_byte_i,
  input  wire logic                           sda_sample_i,
  input  wire logic [DelayBits-1:0]           half_bit_delay_i,
  input  wire logic [i2cm_pkg::PollBits-1:0]  ack_poll_limit_i,
  output i2cm_pkg::res_t                      res_o
);

  localparam logic [4:0] PhIdle    = 5'd0;
  localparam logic [4:0] PhStA     = 5'd1;
  localparam logic [4:0] PhStB     = 5'd2;
  localparam logic [4:0] PhStC     = 5'd3;
  localparam logic [4:0] PhStD     = 5'd4;
  localparam logic [4:0] PhSpA     = 5'd5;
  localparam logic [4:0] PhSpB     = 5'd6;
  localparam logic [4:0] PhSpC     = 5'd7;
  localparam logic [4:0] PhWrLow   = 5'd8;
  localparam logic [4:0] PhWrData  = 5'd9;
  localparam logic [4:0] PhWrHigh  = 5'd10;
  localparam logic [4:0] PhWrALow  = 5'd11;
  localparam logic [4:0] PhWrRel   = 5'd12;
  localparam logic [4:0] PhWrAHigh = 5'd13;
  localparam logic [4:0] PhWrPoll  = 5'd14;
  localparam logic [4:0] PhRdLow   = 5'd15;
  localparam logic [4:0] PhRdRel   = 5'd16;
  localparam logic [4:0] PhRdHigh  = 5'd17;
  localparam logic [4:0] PhRdSamp  = 5'd18;
  localparam logic [4:0] PhRaDrv   = 5'd19;
  localparam logic [4:0] PhRaHigh  = 5'd20;
  localparam logic [4:0] PhFin     = 5'd21;

  localparam int BB = i2cm_pkg::ByteBits;
  localparam int PB = i2cm_pkg::PollBits;

  logic [4:0]           phase_q, phase_d;
  logic [2:0]           cmd_q, cmd_d;
  logic [3:0]           bit_q, bit_d;
  logic [BB-1:0]        shift_q, shift_d;
  logic [DelayBits-1:0] wait_q, wait_d;
  logic [PB-1:0]        poll_q, poll_d;
  logic                 scl_q, scl_d;
  logic                 sda_q, sda_d;
  logic                 oe_q, oe_d;
  logic                 ack_q, ack_d;
  logic [BB-1:0]        hold_q, hold_d;

  logic                 act_en;
  logic [4:0]           act_phase;
  logic [BB-1:0]        act_shift;
  logic [3:0]           act_bit;
  logic [PB-1:0]        act_poll;
  logic [3:0]           bit_inc;
  logic [BB-1:0]        shift_in;
  logic                 done;
  logic                 cmd_valid;

  assign cmd_valid = (req_type_i == i2cm_pkg::ReqStart) || (req_type_i == i2cm_pkg::ReqStop)
                  || (req_type_i == i2cm_pkg::ReqWrite) || (req_type_i == i2cm_pkg::ReqRead)
                  || (req_type_i == i2cm_pkg::ReqReadAck);

  always_comb begin
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    bit_d     = bit_q;
    shift_d   = shift_q;
    wait_d    = wait_q;
    poll_d    = poll_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    oe_d      = oe_q;
    ack_d     = ack_q;
    hold_d    = hold_q;
    done      = 1'b0;
    act_en    = 1'b0;
    act_phase = phase_q;
    act_shift = shift_q;
    act_bit   = bit_q;
    act_poll  = poll_q;

    // pick what this tick does: launch a command, count down, or act
    if (phase_q == PhIdle) begin
      act_en   = cmd_valid;
      act_bit  = '0;
      act_poll = '0;
      priority if (req_type_i == i2cm_pkg::ReqStart) begin
        act_phase = PhStA;
        act_shift = shift_q;
      end else if (req_type_i == i2cm_pkg::ReqStop) begin
        act_phase = PhSpA;
        act_shift = shift_q;
      end else if (req_type_i == i2cm_pkg::ReqWrite) begin
        act_phase = PhWrLow;
        act_shift = write_byte_i;
      end else begin
        act_phase = PhRdLow;
        act_shift = '0;
      end
      if (cmd_valid) begin
        cmd_d = req_type_i;
      end
    end else if (wait_q != '0) begin
      wait_d = wait_q - DelayBits'(1);
    end else begin
      act_en = 1'b1;
    end

    bit_inc  = act_bit + 4'd1;
    shift_in = {act_shift[BB-2:0], sda_sample_i};

    if (act_en) begin
      bit_d   = act_bit;
      shift_d = act_shift;
      poll_d  = act_poll;
      phase_d = PhFin;
      wait_d  = half_bit_delay_i;
      unique case (act_phase)
        PhStA: begin
          oe_d = 1'b1; sda_d = 1'b1; phase_d = PhStB;
        end
        PhStB: begin
          scl_d = 1'b1; phase_d = PhStC;
        end
        PhStC: begin
          sda_d = 1'b0; phase_d = PhStD;
        end
        PhStD: begin
          scl_d = 1'b0;
        end
        PhSpA: begin
          oe_d = 1'b1; sda_d = 1'b0; phase_d = PhSpB;
        end
        PhSpB: begin
          scl_d = 1'b1; phase_d = PhSpC;
        end
        PhSpC: begin
          sda_d = 1'b1;
        end
        PhWrLow: begin
          oe_d = 1'b1; scl_d = 1'b0; phase_d = PhWrData;
        end
        PhWrData: begin
          sda_d = act_shift[BB-1]; phase_d = PhWrHigh;
        end
        PhWrHigh: begin
          scl_d   = 1'b1;
          shift_d = {act_shift[BB-2:0], 1'b0};
          bit_d   = bit_inc;
          phase_d = bit_inc[3] ? PhWrALow : PhWrLow;
        end
        PhWrALow: begin
          scl_d = 1'b0; phase_d = PhWrRel;
        end
        PhWrRel: begin
          sda_d = 1'b1; oe_d = 1'b0; phase_d = PhWrAHigh;
        end
        PhWrAHigh: begin
          scl_d = 1'b1; poll_d = '0; phase_d = PhWrPoll;
        end
        PhWrPoll: begin
          priority if (act_poll >= ack_poll_limit_i) begin
            scl_d = 1'b0; ack_d = 1'b0;
          end else if (!sda_sample_i) begin
            scl_d = 1'b0; ack_d = 1'b1;
          end else begin
            // keep sampling next tick without a wait
            poll_d  = act_poll + PB'(1);
            phase_d = PhWrPoll;
            wait_d  = wait_q;
          end
        end
        PhRdLow: begin
          oe_d = 1'b1; scl_d = 1'b0; phase_d = PhRdRel;
        end
        PhRdRel: begin
          sda_d = 1'b1; oe_d = 1'b0; phase_d = PhRdHigh;
        end
        PhRdHigh: begin
          scl_d = 1'b1; phase_d = PhRdSamp;
        end
        PhRdSamp: begin
          shift_d = shift_in;
          scl_d   = 1'b0;
          bit_d   = bit_inc;
          if (bit_inc[3]) begin
            hold_d  = shift_in;
            phase_d = (cmd_q == i2cm_pkg::ReqReadAck) ? PhRaDrv : PhFin;
          end else begin
            phase_d = PhRdHigh;
          end
        end
        PhRaDrv: begin
          oe_d = 1'b1; sda_d = 1'b0; phase_d = PhRaHigh;
        end
        PhRaHigh: begin
          scl_d = 1'b1;
        end
        default: begin
          // final tick and unused codes end the command
          phase_d = PhIdle;
          wait_d  = wait_q;
          done    = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      cmd_q   <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      wait_q  <= '0;
      poll_q  <= '0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      oe_q    <= 1'b1;
      ack_q   <= 1'b0;
      hold_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      wait_q  <= wait_d;
      poll_q  <= poll_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      oe_q    <= oe_d;
      ack_q   <= ack_d;
      hold_q  <= hold_d;
    end
  end

  always_comb begin
    res_o.scl     = scl_d;
    res_o.sda     = sda_d;
    res_o.oe      = oe_d;
    res_o.busy    = (phase_d != PhIdle);
    res_o.done    = done;
    res_o.ack     = ack_d;
    res_o.rd_data = hold_d;
  end

endmodule

`default_nettype wire

// ----- rtl/core/i2c_master_byte_engine_unit.sv -----
`default_nettype none

// a request's result is registered: the request is held in the input register,
// then its line state update enters the result register once that is free
// throughput: one request per cycle while the output is not stalled, one result per request
// reset: bus idle with scl high and sda driven high, wait and poll counters zero,
// half-bit delay 100 and poll limit 255, both stages empty
module i2c_master_byte_engine_unit #(
  parameter int DelayBits = i2cm_pkg::DelayBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [i2cm_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [i2cm_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [2:0]                      req_type_i,
  input  wire logic [i2cm_pkg::ByteBits-1:0]   write_byte_i,
  input  wire logic                            sda_sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic                                 scl_level_o,
  output logic                                 sda_level_o,
  output logic                                 sda_output_enable_o,
  output logic                                 busy_res_o,
  output logic                                 done_res_o,
  output logic                                 ack_seen_o,
  output logic [i2cm_pkg::ByteBits-1:0]        read_data_o
);

  logic [DelayBits-1:0]                hbd;
  logic [i2cm_pkg::PollBits-1:0]       apl;

  logic                                in_vld_q, in_vld_d;
  logic [2:0]                          req_q;
  logic [i2cm_pkg::ByteBits-1:0]       wbyte_q;
  logic                                sda_in_q;
  logic                                out_vld_q, out_vld_d;
  i2cm_pkg::res_t                      res;
  i2cm_pkg::res_t                      res_q;
  logic                                advance;
  logic                                accept;

  i2cm_cfg_regs #(
    .DelayBits (DelayBits)
  ) u_cfg (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .half_bit_delay_o (hbd),
    .ack_poll_limit_o (apl)
  );

  // request moves on when the result register is free or being drained
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  i2cm_line_fsm #(
    .DelayBits (DelayBits)
  ) u_fsm (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (advance),
    .req_type_i       (req_q),
    .write_byte_i     (wbyte_q),
    .sda_sample_i     (sda_in_q),
    .half_bit_delay_i (hbd),
    .ack_poll_limit_i (apl),
    .res_o            (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_type_i;
      wbyte_q  <= write_byte_i;
      sda_in_q <= sda_sample_i;
    end
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign scl_level_o         = res_q.scl;
  assign sda_level_o         = res_q.sda;
  assign sda_output_enable_o = res_q.oe;
  assign busy_res_o          = res_q.busy;
  assign done_res_o          = res_q.done;
  assign ack_seen_o          = res_q.ack;
  assign read_data_o         = res_q.rd_data;

endmodule

`default_nettype wire
